>>> hw/rtl/sldl_pkg.sv
// Shared types and constants for the speed and line-follow drive loop.
package sldl_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;
    localparam int MAG_W      = 13;
    localparam int FE_W       = 28;
    localparam int ACC_W      = 56;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_TARGET_SPEED = 3'd0;
    localparam logic [2:0] REG_SPEED_KP     = 3'd1;
    localparam logic [2:0] REG_SPEED_KI     = 3'd2;
    localparam logic [2:0] REG_LINE_KP      = 3'd3;
    localparam logic [2:0] REG_LINE_KD      = 3'd4;
    localparam logic [2:0] REG_SPEED_OFFSET = 3'd5;
    localparam logic [2:0] REG_INT_ENABLE   = 3'd6;

    // Reset values of the configuration registers
    localparam logic signed [11:0] TARGET_SPEED_RST = 12'sd1000;
    localparam logic [14:0]        SPEED_KP_RST     = 15'd1178;
    localparam logic [15:0]        SPEED_KI_RST     = 16'd1507;

    // ceil-ish 2^32/10, quotient corrected afterwards
    localparam logic signed [31:0] DIV10_RECIP = 32'sd429496730;
    localparam logic signed [32:0] TURN_DRIVE  = 33'sd800;

    typedef struct packed {
        logic signed [11:0] target_speed;
        logic        [14:0] speed_kp;
        logic        [15:0] speed_ki;
        logic signed [7:0]  line_kp;
        logic signed [13:0] line_kd;
        logic signed [11:0] speed_offset;
        logic               integrator_enable;
    } t_cfg;

    typedef enum logic [2:0] {
        MUL_DIV       = 3'd0,
        MUL_FE_KP     = 3'd1,
        MUL_EI_KI     = 3'd2,
        MUL_LKP_BIAS  = 3'd3,
        MUL_LKD_DBIAS = 3'd4
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD       = 2'd0,
        ACC_LOAD_SPEED = 2'd1,
        ACC_ADD        = 2'd2,
        ACC_LOAD_STEER = 2'd3
    } t_acc_op;

    typedef struct packed {
        logic     load;
        t_mul_sel mul_sel;
        logic     fe_we;
        logic     ei_we;
        t_acc_op  acc_op;
        logic     speed_we;
        logic     out_we;
    } t_dp_cmd;

endpackage

>>> hw/rtl/speed_and_line_follow_drive_loop.sv
// Top level of the speed PI and line-follow PD drive loop.
//
//  channel    dir  beat content
//  s_axis     in   tdata: left_count, right_count, line_bias; tuser: turn_override
//  m_axis     out  tdata: left_magnitude, left_reverse, right_magnitude, right_reverse
//  apb        in   seven control registers at byte addresses 0x00..0x18
//
// Input beats are taken only in the idle state: one load step, then eight steps
// of the sequencer, all sharing a single 32x32 multiplier. The result is written
// at the final step into an output register; the next tick is taken while it waits.
// If the previous result is still held at the final step, the sequencer waits there.
// Synchronous active-low reset restores register defaults and clears the loop state.
module speed_and_line_follow_drive_loop #(
    parameter int DRIVE_LIMIT    = 7000,
    parameter int INTEGRAL_LIMIT = 3000
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [15:0] left_count, [31:16] right_count, [39:32] line_bias
    input  logic [sldl_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // [0] turn_override
    input  logic                                i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [12:0] left_magnitude, [13] left_reverse, [26:14] right_magnitude,
    // [27] right_reverse, [31:28] zero
    output logic [sldl_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sldl_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    sldl_pkg::t_cfg    cfg;
    sldl_pkg::t_dp_cmd cmd;

    sldl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sldl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd)
    );

    sldl_dp #(
        .DRIVE_LIMIT    (DRIVE_LIMIT),
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg      (cfg),
        .i_in_data  (i_s_axis_tdata),
        .i_in_turn  (i_s_axis_tuser),
        .o_out_data (o_m_axis_tdata)
    );

    // only one tick in the sequencer at a time
    ap_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken while a tick is in progress");

    // a fresh result always returns the sequencer to accepting
    ap_result_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> o_s_axis_tready)
        else $error("result written but sequencer not idle");

    ap_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (DRIVE_LIMIT > 8191) ||
                            (32'(o_m_axis_tdata[12:0]) <= DRIVE_LIMIT))
        else $error("left drive beyond saturation limit");

    ap_forward_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[13] && (DRIVE_LIMIT < 8192))
            |-> (o_m_axis_tdata[12:0] != 13'd0))
        else $error("forward left drive with zero magnitude");

endmodule

>>> hw/rtl/sldl_cfg.sv
// APB configuration register file for the drive loop.
module sldl_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sldl_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output sldl_pkg::t_cfg                    o_cfg
);

    sldl_pkg::t_cfg r_cfg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_speed      <= sldl_pkg::TARGET_SPEED_RST;
            r_cfg.speed_kp          <= sldl_pkg::SPEED_KP_RST;
            r_cfg.speed_ki          <= sldl_pkg::SPEED_KI_RST;
            r_cfg.line_kp           <= '0;
            r_cfg.line_kd           <= '0;
            r_cfg.speed_offset      <= '0;
            r_cfg.integrator_enable <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                sldl_pkg::REG_TARGET_SPEED: r_cfg.target_speed      <= pwdata[11:0];
                sldl_pkg::REG_SPEED_KP:     r_cfg.speed_kp          <= pwdata[14:0];
                sldl_pkg::REG_SPEED_KI:     r_cfg.speed_ki          <= pwdata[15:0];
                sldl_pkg::REG_LINE_KP:      r_cfg.line_kp           <= pwdata[7:0];
                sldl_pkg::REG_LINE_KD:      r_cfg.line_kd           <= pwdata[13:0];
                sldl_pkg::REG_SPEED_OFFSET: r_cfg.speed_offset      <= pwdata[11:0];
                sldl_pkg::REG_INT_ENABLE:   r_cfg.integrator_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            sldl_pkg::REG_TARGET_SPEED: prdata = {20'd0, r_cfg.target_speed};
            sldl_pkg::REG_SPEED_KP:     prdata = {17'd0, r_cfg.speed_kp};
            sldl_pkg::REG_SPEED_KI:     prdata = {16'd0, r_cfg.speed_ki};
            sldl_pkg::REG_LINE_KP:      prdata = {24'd0, r_cfg.line_kp};
            sldl_pkg::REG_LINE_KD:      prdata = {18'd0, r_cfg.line_kd};
            sldl_pkg::REG_SPEED_OFFSET: prdata = {20'd0, r_cfg.speed_offset};
            sldl_pkg::REG_INT_ENABLE:   prdata = {31'd0, r_cfg.integrator_enable};
            default:                    prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/sldl_ctrl.sv
// Sequencer for the drive loop: steps the shared multiplier and accumulator.
module sldl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sldl_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_DIV  = 9'b000000010,
        ST_FIX  = 9'b000000100,
        ST_INTG = 9'b000001000,
        ST_SPK  = 9'b000010000,
        ST_SPI  = 9'b000100000,
        ST_STP  = 9'b001000000,
        ST_STE  = 9'b010000000,
        ST_OUT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state          = r_state;
        o_cmd.load       = 1'b0;
        o_cmd.mul_sel    = sldl_pkg::MUL_DIV;
        o_cmd.fe_we      = 1'b0;
        o_cmd.ei_we      = 1'b0;
        o_cmd.acc_op     = sldl_pkg::ACC_HOLD;
        o_cmd.speed_we   = 1'b0;
        o_cmd.out_we     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.mul_sel = sldl_pkg::MUL_DIV;
                n_state       = ST_FIX;
            end
            ST_FIX: begin
                o_cmd.fe_we = 1'b1;
                n_state     = ST_INTG;
            end
            ST_INTG: begin
                o_cmd.ei_we   = 1'b1;
                o_cmd.mul_sel = sldl_pkg::MUL_FE_KP;
                n_state       = ST_SPK;
            end
            ST_SPK: begin
                o_cmd.mul_sel = sldl_pkg::MUL_EI_KI;
                o_cmd.acc_op  = sldl_pkg::ACC_LOAD_SPEED;
                n_state       = ST_SPI;
            end
            ST_SPI: begin
                o_cmd.mul_sel = sldl_pkg::MUL_LKP_BIAS;
                o_cmd.acc_op  = sldl_pkg::ACC_ADD;
                n_state       = ST_STP;
            end
            ST_STP: begin
                o_cmd.mul_sel  = sldl_pkg::MUL_LKD_DBIAS;
                o_cmd.acc_op   = sldl_pkg::ACC_LOAD_STEER;
                o_cmd.speed_we = 1'b1;
                n_state        = ST_STE;
            end
            ST_STE: begin
                o_cmd.acc_op = sldl_pkg::ACC_ADD;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_we = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign n_out_valid = (r_out_valid && !i_out_ready) || o_cmd.out_we;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> hw/rtl/sldl_dp.sv
// Datapath of the drive loop: filter, integrator, shared multiplier, drive mixing.
module sldl_dp #(
    parameter int DRIVE_LIMIT    = 7000,
    parameter int INTEGRAL_LIMIT = 3000
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sldl_pkg::t_dp_cmd                   i_cmd,
    input  sldl_pkg::t_cfg                      i_cfg,
    input  logic [sldl_pkg::IN_DATA_W-1:0]      i_in_data,
    input  logic                                i_in_turn,
    output logic [sldl_pkg::OUT_DATA_W-1:0]     o_out_data
);

    localparam int ILIM = INTEGRAL_LIMIT * 256;
    localparam int EI_W = $clog2(ILIM + 1) + 1;
    localparam int AW   = sldl_pkg::ACC_W;
    localparam int FW   = sldl_pkg::FE_W;
    localparam int MW   = sldl_pkg::MAG_W;
    localparam logic signed [31:0]   ILIM_S = 32'(ILIM);
    localparam logic signed [32:0]   DLIM_S = 33'(DRIVE_LIMIT);
    localparam logic signed [AW-1:0] RND24  = (AW'(1) <<< 24) - AW'(1);
    localparam logic signed [AW-1:0] RND12  = (AW'(1) <<< 12) - AW'(1);

    logic signed [15:0]    in_lc, in_rc;
    logic signed [7:0]     in_bias;
    logic signed [17:0]    n_err;
    logic signed [31:0]    n_num;

    logic signed [31:0]    r_num;
    logic signed [7:0]     r_bias, r_prev_bias;
    logic                  r_turn;
    logic signed [FW-1:0]  r_fe;
    logic signed [EI_W-1:0] r_ei;
    logic signed [63:0]    r_prod;
    logic signed [AW-1:0]  r_acc;
    logic signed [31:0]    r_speed;
    logic [sldl_pkg::OUT_DATA_W-1:0] r_out;

    logic signed [31:0]    mul_a, mul_b;
    logic signed [8:0]     dbias;
    logic signed [31:0]    q_est, n_fe_full;
    logic signed [35:0]    q_x10, rem;
    logic signed [31:0]    ei_sum;
    logic signed [EI_W-1:0] n_ei;
    logic signed [AW-1:0]  prod_ext, acc_shr24, acc_shr12;
    logic signed [31:0]    n_speed, steer;
    logic signed [32:0]    left_raw, right_raw, left_sat, right_sat;
    logic [MW:0]           left_code, right_code;

    function automatic logic signed [32:0] sat_drive(input logic signed [32:0] v);
        logic signed [32:0] r;
        if (v > DLIM_S) begin
            r = DLIM_S;
        end else if (v < -DLIM_S) begin
            r = -DLIM_S;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // {reverse, magnitude}; zero counts as reverse
    function automatic logic [MW:0] drive_code(input logic signed [32:0] d);
        logic signed [32:0] a;
        a = (d < 0) ? -d : d;
        return {(d <= 0), a[MW-1:0]};
    endfunction

    assign in_lc   = i_in_data[15:0];
    assign in_rc   = i_in_data[31:16];
    assign in_bias = i_in_data[39:32];

    // new filter numerator: 768*err + 7*fe
    always_comb begin
        n_err = 18'(i_cfg.target_speed) - (18'(in_lc) + 18'(in_rc));
        n_num = (32'(n_err) <<< 9) + (32'(n_err) <<< 8) + (32'(r_fe) <<< 3) - 32'(r_fe);
    end

    assign dbias = 9'(r_bias) - 9'(r_prev_bias);

    always_comb begin
        case (i_cmd.mul_sel)
            sldl_pkg::MUL_DIV: begin
                mul_a = r_num;
                mul_b = sldl_pkg::DIV10_RECIP;
            end
            sldl_pkg::MUL_FE_KP: begin
                mul_a = 32'(r_fe);
                mul_b = $signed({17'd0, i_cfg.speed_kp});
            end
            sldl_pkg::MUL_EI_KI: begin
                mul_a = 32'(r_ei);
                mul_b = $signed({16'd0, i_cfg.speed_ki});
            end
            sldl_pkg::MUL_LKP_BIAS: begin
                mul_a = 32'(i_cfg.line_kp);
                mul_b = 32'(r_bias);
            end
            sldl_pkg::MUL_LKD_DBIAS: begin
                mul_a = 32'(i_cfg.line_kd);
                mul_b = 32'(dbias);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // floor(num/10): estimate from reciprocal product, then one-step fix
    always_comb begin
        q_est = r_prod[63:32];
        q_x10 = (36'(q_est) <<< 3) + (36'(q_est) <<< 1);
        rem   = 36'(r_num) - q_x10;
        if (rem < 0) begin
            n_fe_full = q_est - 32'sd1;
        end else if (rem >= 36'sd10) begin
            n_fe_full = q_est + 32'sd1;
        end else begin
            n_fe_full = q_est;
        end
    end

    always_comb begin
        ei_sum = 32'(r_ei) + 32'(r_fe) - (32'(i_cfg.speed_offset) <<< 8);
        if (!i_cfg.integrator_enable) begin
            n_ei = '0;
        end else if (ei_sum > ILIM_S) begin
            n_ei = EI_W'(ILIM_S);
        end else if (ei_sum < -ILIM_S) begin
            n_ei = EI_W'(-ILIM_S);
        end else begin
            n_ei = ei_sum[EI_W-1:0];
        end
    end

    // truncation toward zero of the accumulator
    always_comb begin
        prod_ext  = r_prod[AW-1:0];
        acc_shr24 = (r_acc < 0) ? ((r_acc + RND24) >>> 24) : (r_acc >>> 24);
        acc_shr12 = (r_acc < 0) ? ((r_acc + RND12) >>> 12) : (r_acc >>> 12);
        n_speed   = acc_shr24[31:0];
        steer     = acc_shr12[31:0];
    end

    always_comb begin
        if (r_turn) begin
            left_raw  = sldl_pkg::TURN_DRIVE;
            right_raw = -sldl_pkg::TURN_DRIVE;
        end else begin
            left_raw  = 33'(r_speed) + 33'(steer);
            right_raw = 33'(r_speed) - 33'(steer);
        end
        left_sat   = sat_drive(left_raw);
        right_sat  = sat_drive(right_raw);
        left_code  = drive_code(left_sat);
        right_code = drive_code(right_sat);
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (i_cmd.load) begin
            r_num  <= n_num;
            r_bias <= in_bias;
            r_turn <= i_in_turn;
        end
        case (i_cmd.acc_op)
            sldl_pkg::ACC_LOAD_SPEED: r_acc <= prod_ext <<< 8;
            sldl_pkg::ACC_ADD:        r_acc <= r_acc + prod_ext;
            sldl_pkg::ACC_LOAD_STEER: r_acc <= prod_ext <<< 12;
            default: ;
        endcase
        if (i_cmd.speed_we) begin
            r_speed <= n_speed;
        end
        if (i_cmd.out_we) begin
            r_out <= {{(sldl_pkg::OUT_DATA_W - 2*(MW+1)){1'b0}}, right_code, left_code};
        end
    end

    // loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fe        <= '0;
            r_ei        <= '0;
            r_prev_bias <= '0;
        end else begin
            if (i_cmd.fe_we) begin
                r_fe <= n_fe_full[FW-1:0];
            end
            if (i_cmd.ei_we) begin
                r_ei <= n_ei;
            end
            if (i_cmd.out_we) begin
                r_prev_bias <= r_bias;
            end
        end
    end

    assign o_out_data = r_out;

endmodule
